FILE: rtl/pwmhb_pkg.sv
// ============================================================================
// pwmhb_pkg: shared types and constants for the H-bridge PWM drive
// Beat layouts, mode and register codes, and the small helper functions used
// by the drive logic.
// ============================================================================
package pwmhb_pkg;

    localparam logic [6:0] TICKS_PER_STEP  = 7'd100;
    localparam logic [7:0] STRAIGHT_PERIOD = 8'd8;
    localparam logic [7:0] TURN_PERIOD     = 8'd255;
    localparam logic [7:0] TURN_HALF       = 8'd127;
    localparam logic [7:0] TURN_FULL       = 8'(2 * TURN_HALF);

    localparam logic [7:0] RESET_SPEED = 8'd3;

    // Bridge enable bits.
    localparam logic [4:0] BIT_M1 = 5'b00001;
    localparam logic [4:0] BIT_MP = 5'b00010;
    localparam logic [4:0] BIT_M2 = 5'b01000;
    localparam logic [4:0] BIT_MN = 5'b10000;

    // Drive modes.
    localparam logic [2:0] MODE_FWD = 3'd0;
    localparam logic [2:0] MODE_BK  = 3'd1;
    localparam logic [2:0] MODE_TL  = 3'd2;
    localparam logic [2:0] MODE_TR  = 3'd3;

    // Beat kinds.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WALK_ENABLE = 2'd0;
    localparam logic [1:0] CFG_WALK_SPEED  = 2'd1;

    // Reciprocal of ten for 9-bit values: (v * 205) >> 11 is exact below 1029.
    localparam logic [16:0] RECIP_TEN   = 17'd205;
    localparam int          RECIP_SHIFT = 11;

    typedef struct packed {
        logic        kind;
        logic [2:0]  mode;
        logic [7:0]  speed_right;
        logic [7:0]  speed_left;
        logic [15:0] rand_mode_value;
        logic [15:0] rand_thresh_value;
    } item_t;

    typedef struct packed {
        logic [4:0] drive_bits;
        logic       time_step;
    } result_t;

    // Pattern builder result: drive bits plus the state it rewrites.
    typedef struct packed {
        logic [4:0] drive_bits;
        logic [7:0] period;
        logic [7:0] right_speed;
        logic [7:0] left_speed;
    } pattern_t;

    // Walk sequence code to drive mode.
    function automatic logic [2:0] walk_map(input logic [1:0] code);
        logic [2:0] m;
        case (code)
            2'd0:    m = MODE_FWD;
            2'd1:    m = MODE_TL;
            2'd2:    m = MODE_BK;
            default: m = MODE_TR;
        endcase
        return m;
    endfunction

    // Next walk code: (r >> 7) mod 10, folded to zero above three.
    function automatic logic [1:0] walk_pick(input logic [15:0] r);
        logic [8:0]  v;
        logic [16:0] prod;
        logic [5:0]  q;
        logic [8:0]  qx10;
        logic [8:0]  rem;
        v    = r[15:7];
        prod = {8'd0, v} * RECIP_TEN;
        q    = prod[16:RECIP_SHIFT];
        qx10 = {3'd0, q} * 9'd10;
        rem  = v - qx10;
        return (rem <= 9'd3) ? rem[1:0] : 2'd0;
    endfunction

endpackage

FILE: rtl/pwmhb_pattern.sv
// ============================================================================
// pwmhb_pattern: H-bridge drive pattern builder
// Compares the PWM counter with the motor speeds for the current mode and
// returns the enable bits together with the period and speeds the mode forces.
// ============================================================================
module pwmhb_pattern
(
    input  logic [2:0]          mode,
    input  logic [7:0]          pwm_count,
    input  logic [7:0]          pwm_period,
    input  logic [7:0]          right_speed,
    input  logic [7:0]          left_speed,
    output pwmhb_pkg::pattern_t pattern
);
    import pwmhb_pkg::*;

    always_comb
    begin
        pattern.drive_bits  = '0;
        pattern.period      = pwm_period;
        pattern.right_speed = right_speed;
        pattern.left_speed  = left_speed;
        case (mode)
            MODE_FWD:
            begin
                pattern.period     = STRAIGHT_PERIOD;
                pattern.drive_bits = BIT_MP | BIT_MN
                                   | ((pwm_count >= right_speed) ? BIT_M2 : 5'd0)
                                   | ((pwm_count >= left_speed)  ? BIT_M1 : 5'd0);
            end
            MODE_BK:
            begin
                pattern.period     = STRAIGHT_PERIOD;
                pattern.drive_bits = ((pwm_count < right_speed) ? BIT_M2 : 5'd0)
                                   | ((pwm_count < left_speed)  ? BIT_M1 : 5'd0);
            end
            MODE_TL:
            begin
                // Forward, then one side backward, then off over one turn period.
                pattern.period     = TURN_PERIOD;
                pattern.left_speed = TURN_HALF;
                if (pwm_count >= TURN_FULL)
                    pattern.drive_bits = '0;
                else if (pwm_count >= TURN_HALF)
                    pattern.drive_bits = BIT_M1;
                else
                    pattern.drive_bits = BIT_M1 | BIT_MP | BIT_MN;
            end
            MODE_TR:
            begin
                pattern.period      = TURN_PERIOD;
                pattern.right_speed = TURN_HALF;
                if (pwm_count >= TURN_FULL)
                    pattern.drive_bits = '0;
                else if (pwm_count >= TURN_HALF)
                    pattern.drive_bits = BIT_M2;
                else
                    pattern.drive_bits = BIT_MP | BIT_MN | BIT_M2;
            end
            default:
            begin
                // Any other mode leaves the motors off and the period alone.
                pattern.drive_bits = '0;
            end
        endcase
    end

endmodule

FILE: rtl/pwm_hbridge_random_walk_drive.sv
// ============================================================================
// pwm_hbridge_random_walk_drive: two-motor H-bridge PWM drive with random walk
// Tick and command beats in, one drive pattern beat out per tick.
// ============================================================================
// The block takes one beat per clock cycle while item_stall is low and returns
// the drive pattern of a tick beat through the output stage; command beats update the mode and
// speeds and return nothing. All state is updated in the cycle a beat is
// accepted, so back-to-back ticks see each other's effect with no bubble. The
// result side has a two-entry output stage (result register plus a skid
// entry), so a tick is still taken while an earlier result waits downstream;
// item_stall rises only when both entries are full. Each tick advances a
// divider that flags time_step on the tick after it has counted to one
// hundred; on such a step, with walk_enable set, a walk counter that matches
// its random interval loads the next walk mode and sets both speeds to
// walk_speed. Forward and back use a PWM period of 8 compared against the
// two speeds; the turn modes use a period of 255 with the turning side forced
// to 127 and go forward, backward, then off. Modes four to seven drive
// nothing. Configuration writes take effect at the clock edge of cfg_we and
// must be made while the block is idle; indexes beyond the two registers are
// ignored.
module pwm_hbridge_random_walk_drive
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,

    input  logic                item_valid,
    output logic                item_stall,
    input  pwmhb_pkg::item_t    item,

    output logic                result_valid,
    input  logic                result_stall,
    output pwmhb_pkg::result_t  result
);
    import pwmhb_pkg::*;

    // Configuration registers.
    logic       walk_enable_reg;
    logic [7:0] walk_speed_reg;

    // Drive state.
    logic [7:0] pwm_count_reg,      pwm_count_next;
    logic [7:0] pwm_period_reg,     pwm_period_next;
    logic [2:0] drive_mode_reg,     drive_mode_next;
    logic [7:0] right_speed_reg,    right_speed_next;
    logic [7:0] left_speed_reg,     left_speed_next;
    logic [6:0] tick_divider_reg,   tick_divider_next;
    logic [7:0] walk_counter_reg,   walk_counter_next;
    logic [7:0] walk_interval_reg,  walk_interval_next;
    logic [1:0] next_walk_mode_reg, next_walk_mode_next;

    // Output stage: result register plus one skid entry.
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg,       main_next;
    result_t skid_reg,       skid_next;

    logic       accept;
    logic       is_tick;
    logic       is_cmd;
    logic       step;
    logic       walk_hit;
    logic [2:0] mode_mid;
    logic [7:0] right_mid;
    logic [7:0] left_mid;
    logic [7:0] count_inc;
    pattern_t   pattern;
    result_t    new_result;
    logic       pop;

    assign accept  = item_valid && !item_stall;
    assign is_tick = accept && (item.kind == KIND_TICK);
    assign is_cmd  = accept && (item.kind == KIND_CMD);

    // The divider rolls over on the tick that finds it at its terminal count.
    assign step     = (tick_divider_reg == TICKS_PER_STEP);
    assign walk_hit = step && walk_enable_reg && (walk_counter_reg == walk_interval_reg);

    // Mode and speeds as the pattern builder sees them, after any walk change.
    assign mode_mid  = walk_hit ? walk_map(next_walk_mode_reg) : drive_mode_reg;
    assign right_mid = walk_hit ? walk_speed_reg : right_speed_reg;
    assign left_mid  = walk_hit ? walk_speed_reg : left_speed_reg;

    pwmhb_pattern u_pattern
    (
        .mode        (mode_mid),
        .pwm_count   (pwm_count_reg),
        .pwm_period  (pwm_period_reg),
        .right_speed (right_mid),
        .left_speed  (left_mid),
        .pattern     (pattern)
    );

    assign count_inc             = pwm_count_reg + 8'd1;
    assign new_result.drive_bits = pattern.drive_bits;
    assign new_result.time_step  = step;

    always_comb
    begin
        pwm_count_next      = pwm_count_reg;
        pwm_period_next     = pwm_period_reg;
        drive_mode_next     = drive_mode_reg;
        right_speed_next    = right_speed_reg;
        left_speed_next     = left_speed_reg;
        tick_divider_next   = tick_divider_reg;
        walk_counter_next   = walk_counter_reg;
        walk_interval_next  = walk_interval_reg;
        next_walk_mode_next = next_walk_mode_reg;

        if (is_cmd)
        begin
            drive_mode_next  = item.mode;
            right_speed_next = item.speed_right;
            left_speed_next  = item.speed_left;
        end
        else if (is_tick)
        begin
            tick_divider_next = step ? 7'd1 : tick_divider_reg + 7'd1;
            if (step && walk_enable_reg)
            begin
                walk_counter_next = (walk_hit ? 8'd0 : walk_counter_reg) + 8'd1;
            end
            if (walk_hit)
            begin
                next_walk_mode_next = walk_pick(item.rand_mode_value);
                walk_interval_next  = item.rand_thresh_value[13:6] + 8'd1;
            end
            drive_mode_next  = mode_mid;
            right_speed_next = pattern.right_speed;
            left_speed_next  = pattern.left_speed;
            pwm_period_next  = pattern.period;
            // A period of zero matches only when the count wraps, so the counter then runs all 256 values.
            pwm_count_next   = (count_inc == pattern.period) ? 8'd0 : count_inc;
        end
    end

    // Output stage: the skid entry only fills while the result register is held.
    assign pop          = main_valid_reg && !result_stall;
    assign item_stall   = skid_valid_reg;
    assign result_valid = main_valid_reg;
    assign result       = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = is_tick;
                main_next       = new_result;
            end
        end
        else if (is_tick)
        begin
            skid_valid_next = 1'b1;
            skid_next       = new_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_enable_reg <= 1'b0;
            walk_speed_reg  <= RESET_SPEED;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WALK_ENABLE: walk_enable_reg <= cfg_data[0];
                CFG_WALK_SPEED:  walk_speed_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_count_reg      <= '0;
            pwm_period_reg     <= STRAIGHT_PERIOD;
            drive_mode_reg     <= MODE_FWD;
            right_speed_reg    <= RESET_SPEED;
            left_speed_reg     <= RESET_SPEED;
            tick_divider_reg   <= '0;
            walk_counter_reg   <= '0;
            walk_interval_reg  <= '0;
            next_walk_mode_reg <= '0;
            main_valid_reg     <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            pwm_count_reg      <= pwm_count_next;
            pwm_period_reg     <= pwm_period_next;
            drive_mode_reg     <= drive_mode_next;
            right_speed_reg    <= right_speed_next;
            left_speed_reg     <= left_speed_next;
            tick_divider_reg   <= tick_divider_next;
            walk_counter_reg   <= walk_counter_next;
            walk_interval_reg  <= walk_interval_next;
            next_walk_mode_reg <= next_walk_mode_next;
            main_valid_reg     <= main_valid_next;
            skid_valid_reg     <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // The skid entry is only ever occupied behind a held result.
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry full while result register is empty");

    // The divider never passes its terminal count.
    a_divider_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_divider_reg <= TICKS_PER_STEP)
        else $error("tick divider out of range");

    // A command beat into an empty output stage produces no result.
    a_cmd_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (is_cmd && !main_valid_reg) |=> !main_valid_reg)
        else $error("command beat produced a result");

    // A result with time_step set comes only from a tick at the divider's end.
    a_step_source: assert property (@(posedge clk) disable iff (!rst_n)
        (is_tick && !main_valid_reg && !skid_valid_reg) |=>
            (main_reg.time_step == $past(step)))
        else $error("time_step does not match the divider");

endmodule
